>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent checks, held off while reset is active
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ilist_pkg.sv
// ----------------------------------------------------------------------------
// ilist_pkg
// shared types, field widths and controller/datapath command and status structs
// ----------------------------------------------------------------------------
package ilist_pkg;

  localparam int VALUE_W    = 32;
  localparam int POS_W      = 7;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int INDEX_W    = 6;
  localparam int COUNT_W    = 7;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_DUMP   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC,
    PTR_USED_M1,
    PTR_POS_P1
  } ptr_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_VALUE,
    WR_UP,
    WR_DOWN
  } wr_sel_t;

  typedef enum logic [1:0] {
    USED_HOLD,
    USED_INC,
    USED_DEC
  } used_op_t;

  typedef struct packed {
    logic     load;
    ptr_op_t  ptr_op;
    logic     rd_en;
    logic     rd_hold;
    wr_sel_t  wr_sel;
    used_op_t used_op;
    logic     out_load;
    status_t  out_status;
    logic     out_idx_hit;
    logic     out_entry_rd;
    logic     out_last;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  empty;
    logic  pos_gt_used;
    logic  pos_eq_used;
    logic  pos_last;
    logic  ptr_eq_pos;
    logic  ptr_last;
    logic  ptr_end;
    logic  rd_vld;
    logic  rd_last;
    logic  match;
    logic  out_free;
  } dp_stat_t;

endpackage

>>> hw/rtl/indexed_list_insert_delete_search.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_search
// packed list of signed words with insert, delete, search and dump
// ----------------------------------------------------------------------------
//  channel   direction  fields
//  in_*      slave      tuser: kind; tdata: value, position
//  out_*     master     tuser: status; tdata: index, entry, count; tlast
//
//  insert and delete move one entry per cycle through the single write
//  port of the store; an append needs no move; dump emits one entry per
//  cycle while the result channel takes them; a failed check gives a
//  single result item
//  reset clears fill count, valid flags and state, no store clearing is needed
//  one item is in work at a time; a stalled result holds the sequencer
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_search #(
  parameter int CAPACITY = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [ilist_pkg::IN_TDATA_W-1:0]      in_tdata,   // value, position
  input  logic [ilist_pkg::KIND_W-1:0]          in_tuser,   // kind
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [ilist_pkg::OUT_TDATA_W-1:0]     out_tdata,  // index, entry, count
  output logic [ilist_pkg::STATUS_W-1:0]        out_tuser,  // status
  output logic                                  out_tlast
);

  import ilist_pkg::*;

  `include "assert_macros.svh"

  localparam int IN_USED_W  = VALUE_W + POS_W;
  localparam int OUT_USED_W = INDEX_W + VALUE_W + COUNT_W;

  dp_cmd_t                   cmd;
  dp_stat_t                  stat;
  status_t                   out_status;
  logic [INDEX_W-1:0]        out_index;
  logic signed [VALUE_W-1:0] out_entry;
  logic [COUNT_W-1:0]        out_count;

  ilist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ilist_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_kind     (kind_t'(in_tuser)),
    .in_value    (in_tdata[VALUE_W-1:0]),
    .in_position (in_tdata[IN_USED_W-1:VALUE_W]),
    .out_tready  (out_tready),
    .out_valid   (out_tvalid),
    .out_status  (out_status),
    .out_index   (out_index),
    .out_entry   (out_entry),
    .out_count   (out_count),
    .out_last    (out_tlast)
  );

  assign out_tuser = out_status;
  assign out_tdata = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, out_count, out_entry, out_index};

  `ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")
  `ASSERT_IMPL(a_no_write_idle, in_tready, cmd.wr_sel == WR_NONE, "store write while idle")
  `ASSERT_IMPL(a_no_overwrite, cmd.out_load, stat.out_free, "result overwritten")
  `ASSERT_IMPL(a_fail_single, out_tvalid && (out_tuser != ST_OK), out_tlast, "failure not last")

endmodule

>>> hw/rtl/ilist_ram.sv
// ----------------------------------------------------------------------------
// ilist_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ilist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/ilist_ctrl.sv
// ----------------------------------------------------------------------------
// ilist_ctrl
// operation sequencer: decode, shift walks, search, dump and result issue
// ----------------------------------------------------------------------------
module ilist_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  ilist_pkg::dp_stat_t stat,
  output ilist_pkg::dp_cmd_t  cmd
);

  import ilist_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SHU,
    S_SHU_TAIL,
    S_INS_WR,
    S_SHD,
    S_SHD_TAIL,
    S_DEL_FIN,
    S_SRCH,
    S_DUMP,
    S_EMIT
  } state_t;

  state_t  state_r, state_nxt;
  status_t res_st_r, res_st_nxt;
  logic    res_hit_r, res_hit_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    res_st_nxt  = res_st_r;
    res_hit_nxt = res_hit_r;
    cmd         = '0;
    cmd.ptr_op  = PTR_HOLD;
    cmd.wr_sel  = WR_NONE;
    cmd.used_op = USED_HOLD;
    cmd.out_status = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        res_hit_nxt = 1'b0;
        res_st_nxt  = ST_OK;
        case (stat.kind)
          KIND_INSERT: begin
            if (stat.full) begin
              res_st_nxt = ST_FULL;
              state_nxt  = S_EMIT;
            end else if (stat.pos_gt_used) begin
              res_st_nxt = ST_BADPOS;
              state_nxt  = S_EMIT;
            end else if (stat.pos_eq_used) begin
              state_nxt = S_INS_WR;
            end else begin
              cmd.ptr_op = PTR_USED_M1;
              state_nxt  = S_SHU;
            end
          end
          KIND_DELETE: begin
            if (stat.empty) begin
              res_st_nxt = ST_EMPTY;
              state_nxt  = S_EMIT;
            end else if (stat.pos_gt_used || stat.pos_eq_used) begin
              res_st_nxt = ST_BADPOS;
              state_nxt  = S_EMIT;
            end else if (stat.pos_last) begin
              state_nxt = S_DEL_FIN;
            end else begin
              cmd.ptr_op = PTR_POS_P1;
              state_nxt  = S_SHD;
            end
          end
          KIND_SEARCH: begin
            if (stat.empty) begin
              res_st_nxt = ST_EMPTY;
              state_nxt  = S_EMIT;
            end else begin
              cmd.ptr_op = PTR_ZERO;
              state_nxt  = S_SRCH;
            end
          end
          default: begin
            if (stat.empty) begin
              res_st_nxt = ST_EMPTY;
              state_nxt  = S_EMIT;
            end else begin
              cmd.ptr_op = PTR_ZERO;
              state_nxt  = S_DUMP;
            end
          end
        endcase
      end
      S_SHU: begin
        cmd.rd_en  = 1'b1;
        cmd.ptr_op = PTR_DEC;
        if (stat.rd_vld) begin
          cmd.wr_sel = WR_UP;
        end
        if (stat.ptr_eq_pos) begin
          state_nxt = S_SHU_TAIL;
        end
      end
      S_SHU_TAIL: begin
        cmd.wr_sel = WR_UP;
        state_nxt  = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.wr_sel  = WR_VALUE;
        cmd.used_op = USED_INC;
        state_nxt   = S_EMIT;
      end
      S_SHD: begin
        cmd.rd_en  = 1'b1;
        cmd.ptr_op = PTR_INC;
        if (stat.rd_vld) begin
          cmd.wr_sel = WR_DOWN;
        end
        if (stat.ptr_last) begin
          state_nxt = S_SHD_TAIL;
        end
      end
      S_SHD_TAIL: begin
        cmd.wr_sel  = WR_DOWN;
        cmd.used_op = USED_DEC;
        state_nxt   = S_EMIT;
      end
      S_DEL_FIN: begin
        cmd.used_op = USED_DEC;
        state_nxt   = S_EMIT;
      end
      S_SRCH: begin
        if (stat.rd_vld && stat.match) begin
          res_st_nxt  = ST_OK;
          res_hit_nxt = 1'b1;
          state_nxt   = S_EMIT;
        end else if (stat.rd_vld && stat.rd_last) begin
          res_st_nxt = ST_NOTFOUND;
          state_nxt  = S_EMIT;
        end else if (!stat.ptr_end) begin
          cmd.rd_en  = 1'b1;
          cmd.ptr_op = PTR_INC;
        end
      end
      S_DUMP: begin
        if (stat.rd_vld && !stat.out_free) begin
          cmd.rd_hold = 1'b1;
        end else begin
          if (stat.rd_vld) begin
            cmd.out_load     = 1'b1;
            cmd.out_status   = ST_OK;
            cmd.out_idx_hit  = 1'b1;
            cmd.out_entry_rd = 1'b1;
            cmd.out_last     = stat.rd_last;
            if (stat.rd_last) begin
              state_nxt = S_IDLE;
            end
          end
          if (!stat.ptr_end) begin
            cmd.rd_en  = 1'b1;
            cmd.ptr_op = PTR_INC;
          end
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_status  = res_st_r;
          cmd.out_idx_hit = res_hit_r;
          cmd.out_last    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      res_st_r  <= ST_OK;
      res_hit_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      res_st_r  <= res_st_nxt;
      res_hit_r <= res_hit_nxt;
    end
  end

endmodule

>>> hw/rtl/ilist_dp.sv
// ----------------------------------------------------------------------------
// ilist_dp
// list store, fill count, walk pointer, compare logic and result register
// ----------------------------------------------------------------------------
module ilist_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ilist_pkg::dp_cmd_t                     cmd,
  output ilist_pkg::dp_stat_t                    stat,
  input  ilist_pkg::kind_t                       in_kind,
  input  logic signed [ilist_pkg::VALUE_W-1:0]   in_value,
  input  logic [ilist_pkg::POS_W-1:0]            in_position,
  input  logic                                   out_tready,
  output logic                                   out_valid,
  output ilist_pkg::status_t                     out_status,
  output logic [ilist_pkg::INDEX_W-1:0]          out_index,
  output logic signed [ilist_pkg::VALUE_W-1:0]   out_entry,
  output logic [ilist_pkg::COUNT_W-1:0]          out_count,
  output logic                                   out_last
);

  import ilist_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int XW   = CMPW + 1;

  kind_t                     kind_r;
  logic signed [VALUE_W-1:0] val_r;
  logic [POS_W-1:0]          pos_r;
  logic [CW-1:0]             used_r, used_nxt;
  logic [CW-1:0]             ptr_r, ptr_nxt;
  logic [AW-1:0]             rd_addr_r;
  logic                      rd_vld_r;

  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [VALUE_W-1:0]        wr_data;
  logic [VALUE_W-1:0]        rd_data;

  logic [XW-1:0] pos_x, used_x, ptr_x, rda_x;

  logic                      out_valid_r;
  status_t                   out_status_r;
  logic [INDEX_W-1:0]        out_index_r;
  logic signed [VALUE_W-1:0] out_entry_r;
  logic [COUNT_W-1:0]        out_count_r;
  logic                      out_last_r;

  ilist_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (ptr_r[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = rd_addr_r;
    wr_data = rd_data;
    case (cmd.wr_sel)
      WR_VALUE: begin
        wr_addr = AW'(pos_r);
        wr_data = val_r;
      end
      WR_UP:   wr_addr = rd_addr_r + AW'(1);
      WR_DOWN: wr_addr = rd_addr_r - AW'(1);
      default: wr_en = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd.ptr_op)
      PTR_ZERO:    ptr_nxt = '0;
      PTR_INC:     ptr_nxt = ptr_r + CW'(1);
      PTR_DEC:     ptr_nxt = ptr_r - CW'(1);
      PTR_USED_M1: ptr_nxt = used_r - CW'(1);
      PTR_POS_P1:  ptr_nxt = CW'(pos_r) + CW'(1);
      default:     ptr_nxt = ptr_r;
    endcase
  end

  always_comb begin
    case (cmd.used_op)
      USED_INC: used_nxt = used_r + CW'(1);
      USED_DEC: used_nxt = used_r - CW'(1);
      default:  used_nxt = used_r;
    endcase
  end

  assign pos_x  = XW'(pos_r);
  assign used_x = XW'(used_r);
  assign ptr_x  = XW'(ptr_r);
  assign rda_x  = XW'(rd_addr_r);

  always_comb begin
    stat.kind        = kind_r;
    stat.full        = (used_r == CW'(CAPACITY));
    stat.empty       = (used_r == '0);
    stat.pos_gt_used = (pos_x > used_x);
    stat.pos_eq_used = (pos_x == used_x);
    stat.pos_last    = ((pos_x + XW'(1)) == used_x);
    stat.ptr_eq_pos  = (ptr_x == pos_x);
    stat.ptr_last    = ((ptr_x + XW'(1)) == used_x);
    stat.ptr_end     = (ptr_x == used_x);
    stat.rd_vld      = rd_vld_r;
    stat.rd_last     = ((rda_x + XW'(1)) == used_x);
    stat.match       = (rd_data == val_r);
    stat.out_free    = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      used_r   <= used_nxt;
      rd_vld_r <= cmd.rd_en || (rd_vld_r && cmd.rd_hold);
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.load) begin
      kind_r <= in_kind;
      val_r  <= in_value;
      pos_r  <= in_position;
    end
    if (cmd.rd_en) begin
      rd_addr_r <= ptr_r[AW-1:0];
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_index_r  <= cmd.out_idx_hit ? INDEX_W'(rd_addr_r) : '0;
      out_entry_r  <= cmd.out_entry_rd ? rd_data : '0;
      out_count_r  <= COUNT_W'(used_r);
      out_last_r   <= cmd.out_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_index  = out_index_r;
  assign out_entry  = out_entry_r;
  assign out_count  = out_count_r;
  assign out_last   = out_last_r;

endmodule

>>> tb/indexed_list_insert_delete_search_tb.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_search_tb
// Drives insert, delete, search and dump requests into the packed list and
// keeps its own copy of the list. Each request is predicted when the block
// accepts it. Every response item is compared field by field with the oldest
// predicted response. Both channels back off at random, with some stretches
// run at full rate.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ilist_pkg::*;

  localparam int LIST_DEPTH   = 64;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 310;

  typedef struct {
    status_t             status;
    logic [INDEX_W-1:0]  index;
    logic [VALUE_W-1:0]  entry;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } list_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // value, position
  logic [KIND_W-1:0]      in_tuser   = '0;   // kind
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // index, entry, count
  logic [STATUS_W-1:0]    out_tuser;         // status
  logic                   out_tlast;

  logic [VALUE_W-1:0] list_entries [LIST_DEPTH];
  int                 list_used = 0;
  list_result_t       pending_results [$];
  int                 error_count = 0;
  bit                 in_idle_on  = 1'b1;
  bit                 out_idle_on = 1'b1;

  indexed_list_insert_delete_search #(
    .CAPACITY(LIST_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic push_result(status_t status, int index, logic [VALUE_W-1:0] entry,
                             logic last);
    list_result_t r;
    r.status = status;
    r.index  = index[INDEX_W-1:0];
    r.entry  = entry;
    r.count  = list_used[COUNT_W-1:0];
    r.last   = last;
    pending_results.push_back(r);
  endtask

  // list model, applied once per accepted item
  task automatic apply_list_op(kind_t kind, logic [VALUE_W-1:0] value, int position);
    int i;
    int hit;
    case (kind)
      KIND_INSERT: begin
        if (list_used >= LIST_DEPTH) begin
          push_result(ST_FULL, 0, '0, 1'b1);
        end else if (position > list_used) begin
          push_result(ST_BADPOS, 0, '0, 1'b1);
        end else begin
          for (i = list_used; i > position; i--) list_entries[i] = list_entries[i-1];
          list_entries[position] = value;
          list_used++;
          push_result(ST_OK, 0, '0, 1'b1);
        end
      end
      KIND_DELETE: begin
        if (list_used == 0) begin
          push_result(ST_EMPTY, 0, '0, 1'b1);
        end else if (position >= list_used) begin
          push_result(ST_BADPOS, 0, '0, 1'b1);
        end else begin
          for (i = position; i + 1 < list_used; i++) list_entries[i] = list_entries[i+1];
          list_used--;
          push_result(ST_OK, 0, '0, 1'b1);
        end
      end
      KIND_SEARCH: begin
        if (list_used == 0) begin
          push_result(ST_EMPTY, 0, '0, 1'b1);
        end else begin
          hit = -1;
          for (i = 0; i < list_used; i++) begin
            if (hit < 0 && list_entries[i] == value) hit = i;
          end
          if (hit >= 0) push_result(ST_OK, hit, '0, 1'b1);
          else push_result(ST_NOTFOUND, 0, '0, 1'b1);
        end
      end
      default: begin
        if (list_used == 0) begin
          push_result(ST_EMPTY, 0, '0, 1'b1);
        end else begin
          for (i = 0; i < list_used; i++)
            push_result(ST_OK, i, list_entries[i], i + 1 == list_used);
        end
      end
    endcase
  endtask

  // called right after a rising edge; leaves tvalid high on return
  task automatic send_list_op(kind_t kind, logic [VALUE_W-1:0] value, int position);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, position[POS_W-1:0], value};
    do @(posedge clk); while (!in_tready);
    apply_list_op(kind, value, position);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4, 5: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  initial begin : result_sink
    list_result_t want;
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = out_idle_on ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected response item, status %0d count %0d", $time,
                 out_tuser, out_tdata[44:38]);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_tuser);
        check_field("index", want.index, out_tdata[5:0]);
        check_field("entry", want.entry, out_tdata[37:6]);
        check_field("count", want.count, out_tdata[44:38]);
        check_field("last", want.last, out_tlast);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic test_empty_list();
    send_list_op(KIND_DELETE, 32'h0, 0);
    send_list_op(KIND_SEARCH, 32'h0, 0);
    send_list_op(KIND_DUMP, 32'hffff_ffff, 127);
    send_list_op(KIND_INSERT, 32'h1234_5678, 1);
    send_list_op(KIND_INSERT, 32'h1234_5678, 127);
    send_list_op(KIND_DELETE, 32'h0, 127);
  endtask

  task automatic test_edit_ops();
    send_list_op(KIND_INSERT, 32'h8000_0000, 0);
    send_list_op(KIND_INSERT, 32'h7fff_ffff, 1);
    send_list_op(KIND_INSERT, 32'h0000_0000, 1);
    send_list_op(KIND_INSERT, 32'hffff_ffff, 0);
    send_list_op(KIND_INSERT, 32'd5, 4);
    send_list_op(KIND_INSERT, 32'd9, 6);
    send_list_op(KIND_SEARCH, 32'h7fff_ffff, 0);
    send_list_op(KIND_SEARCH, 32'h0000_0000, 0);
    // duplicate value, first match wins
    send_list_op(KIND_INSERT, 32'd5, 0);
    send_list_op(KIND_SEARCH, 32'd5, 0);
    send_list_op(KIND_SEARCH, 32'd12345, 0);
    send_list_op(KIND_DELETE, 32'h0, 6);
    send_list_op(KIND_DELETE, 32'h0, 127);
    send_list_op(KIND_DELETE, 32'h0, 2);
    send_list_op(KIND_DELETE, 32'h0, list_used - 1);
    send_list_op(KIND_DELETE, 32'h0, 0);
    send_list_op(KIND_DUMP, 32'h0, 0);
  endtask

  task automatic test_fill_to_capacity();
    logic [VALUE_W-1:0] tail;
    while (list_used < LIST_DEPTH)
      send_list_op(KIND_INSERT, $urandom, $urandom_range(0, list_used));
    send_list_op(KIND_INSERT, 32'h1, 0);
    send_list_op(KIND_INSERT, 32'h1, 127);
    send_list_op(KIND_DUMP, 32'h0, 0);
    tail = list_entries[LIST_DEPTH-1];
    send_list_op(KIND_SEARCH, tail, 0);
    send_list_op(KIND_DELETE, 32'h0, LIST_DEPTH);
    send_list_op(KIND_DELETE, 32'h0, LIST_DEPTH - 1);
    send_list_op(KIND_DELETE, 32'h0, 0);
  endtask

  task automatic test_random_ops();
    int n;
    int pick;
    bit growing;
    int position;
    logic [VALUE_W-1:0] value;
    growing = 1'b0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        in_idle_on  = $urandom_range(0, 3) != 0;
        out_idle_on = $urandom_range(0, 3) != 0;
      end
      if (n % 40 == 0) growing = $urandom_range(0, 1);
      if (list_used >= LIST_DEPTH) growing = 1'b0;
      if (list_used == 0) growing = 1'b1;
      pick     = $urandom_range(0, 99);
      value    = pick_value();
      position = $urandom_range(0, 127);
      if (pick < (growing ? 55 : 20)) begin
        if ($urandom_range(0, 99) < 85) position = $urandom_range(0, list_used);
        send_list_op(KIND_INSERT, value, position);
      end else if (pick < (growing ? 70 : 65)) begin
        if (list_used > 0 && $urandom_range(0, 99) < 85)
          position = $urandom_range(0, list_used - 1);
        send_list_op(KIND_DELETE, value, position);
      end else if (pick < 93) begin
        if (list_used > 0 && $urandom_range(0, 99) < 70)
          value = list_entries[$urandom_range(0, list_used - 1)];
        send_list_op(KIND_SEARCH, value, position);
      end else begin
        send_list_op(KIND_DUMP, value, position);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_edit_ops();
    test_fill_to_capacity();
    test_random_ops();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/ilist_pkg.sv
hw/rtl/ilist_ram.sv
hw/rtl/ilist_ctrl.sv
hw/rtl/ilist_dp.sv
hw/rtl/indexed_list_insert_delete_search.sv
tb/indexed_list_insert_delete_search_tb.sv
